// File: sv/pas_pkg.sv
// Shared types and constants of the pin array spring admittance block.
// Holds the configuration record, the per-pin memory word and the result record.
// No dependencies; every other file of the block but pas_ram imports it.
package pas_pkg;

  localparam int GRID_COLS_DEF = 16;
  localparam int GRID_ROWS_DEF = 16;

  localparam int CFG_INDEX_W = 3;
  localparam int CFG_DATA_W  = 17;

  // Register indexes of the configuration port.
  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_PROP_GAIN      = 3'd0,
    REG_DERIV_GAIN     = 3'd1,
    REG_SPRING_BASE    = 3'd2,
    REG_SPRING_STEP    = 3'd3,
    REG_HEIGHT_FLOOR   = 3'd4,
    REG_HEIGHT_CEILING = 3'd5
  } cfg_reg_t;

  // Clamp status codes on the result channel.
  localparam logic [1:0] CLAMP_NONE    = 2'd0;
  localparam logic [1:0] CLAMP_FLOOR   = 2'd1;
  localparam logic [1:0] CLAMP_CEILING = 2'd2;

  typedef struct packed {
    logic [15:0] prop_gain;
    logic [15:0] deriv_gain;
    logic [11:0] spring_base;
    logic [11:0] spring_step;
    logic [16:0] height_floor;
    logic [16:0] height_ceiling;
  } cfg_t;

  localparam cfg_t CFG_RESET = '{
    prop_gain:      16'd256,
    deriv_gain:     16'd0,
    spring_base:    12'd820,
    spring_step:    12'd90,
    height_floor:   17'd70000,
    height_ceiling: 17'd80000
  };

  // One input beat, without handshake.
  typedef struct packed {
    logic [3:0]  col;
    logic [3:0]  row;
    logic [11:0] force_val;
    logic [16:0] meas;
    logic [15:0] dt;
  } item_t;

  // Per-pin state: velocity Q24.8, last force error, command height Q17.7.
  typedef struct packed {
    logic signed [31:0] speed;
    logic signed [13:0] prev_err;
    logic [23:0]        cmd;
  } mem_word_t;

  localparam logic [23:0] CMD_RESET = 24'd10240000;  // 80000.0 in Q17.7

  localparam mem_word_t MEM_WORD_RESET = '{
    speed:    32'sd0,
    prev_err: 14'sd0,
    cmd:      CMD_RESET
  };

  // Result leaving the last pipeline stage.
  typedef struct packed {
    logic        valid;
    logic [3:0]  col;
    logic [3:0]  row;
    logic [16:0] height;
    logic [1:0]  status;
  } result_t;

endpackage

// File: sv/pin_array_spring_admittance.sv
// Each input beat's result passes the stage registers s1 to s4, then the output register.
// Throughput: one beat per cycle for distinct pins while the output is not stalled; a
// repeat of a pin still in flight waits until that pin's write-back, which ends the
// read-to-write-back loop through the four pipeline stages.
// Reset is synchronous; a clearing pass then loads the state of all GRID_COLS*GRID_ROWS
// pins (256 by default), and no input beat is taken until it ends.
module pin_array_spring_admittance #(
  parameter int GRID_COLS = pas_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = pas_pkg::GRID_ROWS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  // Configuration write channel.
  input  logic                            cfg_valid,
  output logic                            cfg_ready,
  input  logic [pas_pkg::CFG_INDEX_W-1:0] cfg_index,
  input  logic [pas_pkg::CFG_DATA_W-1:0]  cfg_data,
  // Input channel.
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [3:0]                      pin_col,
  input  logic [3:0]                      pin_row,
  input  logic [11:0]                     sensed_force,
  input  logic [16:0]                     sensed_height,
  input  logic [15:0]                     step_time,
  // Result channel.
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [3:0]                      out_col,
  output logic [3:0]                      out_row,
  output logic [16:0]                     target_height,
  output logic [1:0]                      clamp_status
);
  import pas_pkg::*;

  localparam int DEPTH = GRID_COLS * GRID_ROWS;
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int WORD_W = $bits(mem_word_t);

  // Configuration writes are taken in every cycle, also during the clearing pass.
  cfg_t cfg;

  assign cfg_ready = 1'b1;

  pas_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg_valid && cfg_ready),
    .wr_index (cfg_index),
    .wr_data  (cfg_data),
    .cfg      (cfg)
  );

  // After reset the state store is swept once, one pin per cycle, with the reset word.
  logic          clearing;
  logic [AW-1:0] clr_addr;

  always_ff @(posedge clk) begin
    if (rst) begin
      clearing <= 1'b1;
      clr_addr <= '0;
    end else if (clearing) begin
      clr_addr <= clr_addr + AW'(1);
      if (clr_addr == AW'(DEPTH - 1)) begin
        clearing <= 1'b0;
      end
    end
  end

  // Input beat and its pin address. A pin outside the grid is accepted and dropped:
  // it never enters the pipeline, so it neither touches the store nor yields a result.
  item_t         item;
  logic [AW-1:0] in_idx;
  logic          in_grid;

  assign item.col       = pin_col;
  assign item.row       = pin_row;
  assign item.force_val = sensed_force;
  assign item.meas      = sensed_height;
  assign item.dt        = step_time;
  assign in_grid = (int'(pin_row) < GRID_ROWS) && (int'(pin_col) < GRID_COLS);
  assign in_idx  = AW'(int'(pin_row) * GRID_COLS + int'(pin_col));

  // The whole pipeline freezes only while a finished result sits in the last stage
  // and the output register is still holding an earlier result that is not taken.
  result_t   res;
  logic      hazard;
  logic      stall;
  logic      adv;
  logic      issue;

  assign stall    = res.valid && out_valid && !out_ready;
  assign adv      = !stall;
  assign in_ready = !clearing && adv && !hazard;
  assign issue    = in_valid && in_ready && in_grid;

  // State store: the pipeline reads a pin's word on its input beat and writes the
  // updated word back from the last stage; the clearing pass owns the write port first.
  logic          pipe_we;
  logic [AW-1:0] pipe_waddr;
  mem_word_t     pipe_wdata;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  mem_word_t     ram_wdata;
  logic [WORD_W-1:0] ram_rdata;

  assign ram_we    = clearing || pipe_we;
  assign ram_waddr = clearing ? clr_addr : pipe_waddr;
  assign ram_wdata = clearing ? MEM_WORD_RESET : pipe_wdata;

  pas_ram #(
    .WIDTH (WORD_W),
    .DEPTH (DEPTH)
  ) u_state_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (issue),
    .raddr (in_idx),
    .rdata (ram_rdata)
  );

  pas_pipe #(
    .GRID_COLS (GRID_COLS),
    .GRID_ROWS (GRID_ROWS)
  ) u_pipe (
    .clk     (clk),
    .rst     (rst),
    .cfg     (cfg),
    .adv     (adv),
    .issue   (issue),
    .item    (item),
    .idx     (in_idx),
    .rd_data (mem_word_t'(ram_rdata)),
    .hazard  (hazard),
    .wr_en   (pipe_we),
    .wr_addr (pipe_waddr),
    .wr_data (pipe_wdata),
    .res     (res)
  );

  // Output register: it takes a new result whenever the pipeline moves, so the input
  // side keeps flowing while one finished beat waits for the consumer.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv && res.valid) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv && res.valid) begin
      out_col       <= res.col;
      out_row       <= res.row;
      target_height <= res.height;
      clamp_status  <= res.status;
    end
  end

  a_no_beat_while_clearing: assert property (@(posedge clk) disable iff (rst)
    clearing |-> !in_ready)
    else $error("input beat offered during the clearing pass");

  a_no_rw_collision: assert property (@(posedge clk) disable iff (rst)
    (ram_we && issue) |-> (ram_waddr != in_idx))
    else $error("state read and write-back hit the same pin");

  a_result_held: assert property (@(posedge clk) disable iff (rst)
    stall |=> res.valid)
    else $error("finished result lost while the output was blocked");

endmodule

// File: sv/pas_ram.sv
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing; used for the per-pin state store.
module pas_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// File: sv/pas_cfg.sv
// Configuration register file of the pin array spring admittance block.
// Depends on pas_pkg for the register indexes and the configuration record.
module pas_cfg (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              wr_en,
  input  logic [pas_pkg::CFG_INDEX_W-1:0]   wr_index,
  input  logic [pas_pkg::CFG_DATA_W-1:0]    wr_data,
  output pas_pkg::cfg_t                     cfg
);
  import pas_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= CFG_RESET;
    end else if (wr_en) begin
      case (cfg_reg_t'(wr_index))
        REG_PROP_GAIN:      cfg.prop_gain      <= wr_data[15:0];
        REG_DERIV_GAIN:     cfg.deriv_gain     <= wr_data[15:0];
        REG_SPRING_BASE:    cfg.spring_base    <= wr_data[11:0];
        REG_SPRING_STEP:    cfg.spring_step    <= wr_data[11:0];
        REG_HEIGHT_FLOOR:   cfg.height_floor   <= wr_data[16:0];
        REG_HEIGHT_CEILING: cfg.height_ceiling <= wr_data[16:0];
        default: ;
      endcase
    end
  end

endmodule

// File: sv/pas_pipe.sv
// Four-stage update pipeline: force error, PD products, velocity, dt product, clamp.
// Reads the per-pin word delivered by the state RAM and returns the write-back word.
// Depends on pas_pkg.
module pas_pipe #(
  parameter int GRID_COLS = pas_pkg::GRID_COLS_DEF,
  parameter int GRID_ROWS = pas_pkg::GRID_ROWS_DEF,
  localparam int DEPTH = GRID_COLS * GRID_ROWS,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic               clk,
  input  logic               rst,
  input  pas_pkg::cfg_t      cfg,
  input  logic               adv,
  input  logic               issue,
  input  pas_pkg::item_t     item,
  input  logic [AW-1:0]      idx,
  input  pas_pkg::mem_word_t rd_data,
  output logic               hazard,
  output logic               wr_en,
  output logic [AW-1:0]      wr_addr,
  output pas_pkg::mem_word_t wr_data,
  output pas_pkg::result_t   res
);
  import pas_pkg::*;

  // Stage 0, on the input beat: spring target and force error.
  logic [15:0]        col_step;
  logic signed [16:0] spring_raw;
  logic [11:0]        spring;
  logic signed [12:0] err0;

  always_comb begin
    col_step   = 16'(item.col) * 16'(cfg.spring_step);
    spring_raw = $signed({5'b0, cfg.spring_base}) - $signed({1'b0, col_step});
    spring     = spring_raw[16] ? 12'd0 : spring_raw[11:0];
    err0       = $signed({1'b0, item.force_val}) - $signed({1'b0, spring});
  end

  logic               s1_valid, s2_valid, s3_valid, s4_valid;
  logic [AW-1:0]      s1_idx, s2_idx, s3_idx, s4_idx;
  logic [3:0]         s1_col, s2_col, s3_col, s4_col;
  logic [3:0]         s1_row, s2_row, s3_row, s4_row;
  logic [16:0]        s1_meas;
  logic [15:0]        s1_dt, s2_dt, s3_dt;
  logic signed [12:0] s1_err, s2_err, s3_err, s4_err;
  logic signed [29:0] s2_pp;
  logic signed [31:0] s2_pdd;
  logic signed [31:0] s2_speed;
  logic [24:0]        s2_base, s3_base, s4_base;
  logic signed [31:0] s3_v, s4_v;
  logic signed [48:0] s4_prod;

  // Stage 1: RAM word arrives; PD products and the height base.
  logic signed [14:0] diff1;
  logic signed [29:0] pp1;
  logic signed [31:0] pdd1;
  logic [25:0]        cmd3;
  logic [24:0]        base1;

  always_comb begin
    diff1 = {s1_err[12], s1_err[12], s1_err} - {rd_data.prev_err[13], rd_data.prev_err};
    pp1   = $signed({1'b0, cfg.prop_gain}) * s1_err;
    pdd1  = $signed({1'b0, cfg.deriv_gain}) * diff1;
    cmd3  = {2'b0, rd_data.cmd} + {1'b0, rd_data.cmd, 1'b0};
    base1 = {3'b0, s1_meas, 5'b0} + {1'b0, cmd3[25:2]};
  end

  // Stage 2: halved velocity update.
  logic signed [32:0] pd2;
  logic signed [33:0] vdiff2;

  always_comb begin
    pd2    = {{3{s2_pp[29]}}, s2_pp} + {s2_pdd[31], s2_pdd};
    vdiff2 = {{2{s2_speed[31]}}, s2_speed} - {pd2[32], pd2};
  end

  // Stage 3: dt times velocity.
  logic signed [48:0] prod3;

  assign prod3 = $signed({1'b0, s3_dt}) * s3_v;

  // Stage 4: new height, clamping and write-back.
  logic signed [31:0] inc4;
  logic signed [33:0] h4, lo4, hi4, hf4, hfin4;
  logic [1:0]         status4;

  always_comb begin
    inc4    = s4_prod[48:17];
    h4      = $signed({9'b0, s4_base}) + {{2{inc4[31]}}, inc4};
    lo4     = $signed({10'b0, cfg.height_floor, 7'b0});
    hi4     = $signed({10'b0, cfg.height_ceiling, 7'b0});
    status4 = CLAMP_NONE;
    hf4     = h4;
    if (h4 < lo4) begin
      hf4     = lo4;
      status4 = CLAMP_FLOOR;
    end
    hfin4 = hf4;
    if (hf4 > hi4) begin
      hfin4   = hi4;
      status4 = CLAMP_CEILING;
    end
  end

  assign wr_en            = s4_valid && adv;
  assign wr_addr          = s4_idx;
  assign wr_data.speed    = (status4 == CLAMP_NONE) ? s4_v : 32'sd0;
  assign wr_data.prev_err = {s4_err[12], s4_err};
  assign wr_data.cmd      = hfin4[23:0];

  assign res.valid  = s4_valid;
  assign res.col    = s4_col;
  assign res.row    = s4_row;
  assign res.height = hfin4[23:7];
  assign res.status = status4;

  // A pin already in flight must write back before it is read again.
  assign hazard = (s1_valid && s1_idx == idx) || (s2_valid && s2_idx == idx)
               || (s3_valid && s3_idx == idx) || (s4_valid && s4_idx == idx);

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
      s2_valid <= 1'b0;
      s3_valid <= 1'b0;
      s4_valid <= 1'b0;
    end else if (adv) begin
      s1_valid <= issue;
      s2_valid <= s1_valid;
      s3_valid <= s2_valid;
      s4_valid <= s3_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_idx   <= idx;
      s1_col   <= item.col;
      s1_row   <= item.row;
      s1_meas  <= item.meas;
      s1_dt    <= item.dt;
      s1_err   <= err0;

      s2_idx   <= s1_idx;
      s2_col   <= s1_col;
      s2_row   <= s1_row;
      s2_dt    <= s1_dt;
      s2_err   <= s1_err;
      s2_pp    <= pp1;
      s2_pdd   <= pdd1;
      s2_speed <= rd_data.speed;
      s2_base  <= base1;

      s3_idx   <= s2_idx;
      s3_col   <= s2_col;
      s3_row   <= s2_row;
      s3_dt    <= s2_dt;
      s3_err   <= s2_err;
      s3_base  <= s2_base;
      s3_v     <= vdiff2[32:1];

      s4_idx   <= s3_idx;
      s4_col   <= s3_col;
      s4_row   <= s3_row;
      s4_err   <= s3_err;
      s4_base  <= s3_base;
      s4_v     <= s3_v;
      s4_prod  <= prod3;
    end
  end

  a_no_dup_pin: assert property (@(posedge clk) disable iff (rst)
    (s1_valid && s2_valid) |-> (s1_idx != s2_idx))
    else $error("two beats for one pin in adjacent stages");

  a_under_ceiling: assert property (@(posedge clk) disable iff (rst)
    res.valid |-> (res.height <= cfg.height_ceiling))
    else $error("target height above ceiling");

  a_clamp_stops: assert property (@(posedge clk) disable iff (rst)
    (wr_en && res.status != CLAMP_NONE) |-> (wr_data.speed == 32'sd0))
    else $error("velocity kept on a clamped pin");

endmodule

// File: verif/tb.sv
// Self-checking testbench for pin_array_spring_admittance: random and directed pin updates.
// Depends on sv/pas_pkg.sv and the block's RTL; no files, plusargs or foreign code.
`timescale 1ns / 1ps

module tb;
  import pas_pkg::*;

  localparam int GRID_COLS   = GRID_COLS_DEF;
  localparam int GRID_ROWS   = GRID_ROWS_DEF;
  localparam int PIN_COUNT   = GRID_COLS * GRID_ROWS;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASES      = 8;
  localparam int PHASE_BEATS = 165;

  // Indexes past the register list; a write there must leave every register alone.
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_A = 3'd6;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE_B = 3'd7;

  // One expected beat on the result channel.
  typedef struct {
    logic [3:0]  col;
    logic [3:0]  row;
    logic [16:0] height;
    logic [1:0]  status;
  } pin_cmd_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;
  logic                   in_valid = 1'b0;
  logic                   in_ready;
  logic [3:0]             pin_col = '0;
  logic [3:0]             pin_row = '0;
  logic [11:0]            sensed_force = '0;
  logic [16:0]            sensed_height = '0;
  logic [15:0]            step_time = '0;
  logic                   out_valid;
  logic                   out_ready = 1'b0;
  logic [3:0]             out_col;
  logic [3:0]             out_row;
  logic [16:0]            target_height;
  logic [1:0]             clamp_status;

  pin_array_spring_admittance dut (
    .clk(clk), .rst(rst),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_ready(in_ready),
    .pin_col(pin_col), .pin_row(pin_row), .sensed_force(sensed_force),
    .sensed_height(sensed_height), .step_time(step_time),
    .out_valid(out_valid), .out_ready(out_ready),
    .out_col(out_col), .out_row(out_row), .target_height(target_height),
    .clamp_status(clamp_status)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow of the block: its register file and the per-pin state store.
  cfg_t              model_cfg;
  logic signed [31:0] pin_vel_q8    [PIN_COUNT];
  logic signed [13:0] pin_err       [PIN_COUNT];
  logic [23:0]        pin_height_q7 [PIN_COUNT];

  item_t    sensor_beats [$];   // beats waiting for the input driver
  pin_cmd_t expected_cmds [$];  // predicted commands, oldest first
  item_t    next_beat;

  int  beats_queued = 0;
  int  beats_taken  = 0;
  int  mismatches   = 0;
  int  cycle_count  = 0;
  bit  in_took      = 1'b0;
  bit  idle_en      = 1'b1;
  int  send_gap     = 0;
  int  recv_gap     = 0;

  // Runs one pin update on the shadow state and returns the command the block must emit.
  // Everything is done in 64-bit signed arithmetic; >>> on a signed value floors toward
  // minus infinity, which is the rounding the block uses for every shift.
  function automatic pin_cmd_t admit_pin(item_t b);
    int      slot;
    longint  spring, err, pd, vel, h, lo, hi;
    pin_cmd_t r;
    slot   = int'(b.row) * GRID_COLS + int'(b.col);
    spring = longint'(model_cfg.spring_base) - longint'(b.col) * longint'(model_cfg.spring_step);
    if (spring < 0) spring = 0;
    err = longint'(b.force_val) - spring;
    pd  = longint'(model_cfg.prop_gain) * err
        + longint'(model_cfg.deriv_gain) * (err - longint'(pin_err[slot]));
    vel = (longint'(pin_vel_q8[slot]) - pd) >>> 1;
    if (vel > longint'(32'sh7FFF_FFFF)) vel = longint'(32'sh7FFF_FFFF);
    if (vel < -longint'(64'sh8000_0000)) vel = -longint'(64'sh8000_0000);
    pin_err[slot] = err[13:0];

    // Quarter of the measured height, three quarters of the old command, plus dt * v.
    h  = (longint'(b.meas) << 5) + ((3 * longint'(pin_height_q7[slot])) >>> 2)
       + ((longint'(b.dt) * vel) >>> 17);
    lo = longint'(model_cfg.height_floor) << 7;
    hi = longint'(model_cfg.height_ceiling) << 7;
    r.status = CLAMP_NONE;
    if (h < lo) begin
      h = lo;
      vel = 0;
      r.status = CLAMP_FLOOR;
    end
    // The ceiling is checked last, so it wins when the floor sits above it.
    if (h > hi) begin
      h = hi;
      vel = 0;
      r.status = CLAMP_CEILING;
    end
    pin_vel_q8[slot]    = vel[31:0];
    pin_height_q7[slot] = h[23:0];
    r.col    = b.col;
    r.row    = b.row;
    r.height = h[23:7];
    return r;
  endfunction

  // Monitor: everything is sampled at the rising edge. Register writes update the shadow
  // registers, input beats are predicted as they are taken, and result beats are checked
  // against the oldest prediction.
  always @(posedge clk) begin
    pin_cmd_t want;
    in_took <= in_valid && in_ready;
    if (rst) begin
      model_cfg = CFG_RESET;
      for (int k = 0; k < PIN_COUNT; k++) begin
        pin_vel_q8[k]    = '0;
        pin_err[k]       = '0;
        pin_height_q7[k] = CMD_RESET;
      end
    end else begin
      if (cfg_valid && cfg_ready) begin
        // Only the register's own width is kept; other indexes are ignored.
        case (cfg_index)
          REG_PROP_GAIN:      model_cfg.prop_gain      = cfg_data[15:0];
          REG_DERIV_GAIN:     model_cfg.deriv_gain     = cfg_data[15:0];
          REG_SPRING_BASE:    model_cfg.spring_base    = cfg_data[11:0];
          REG_SPRING_STEP:    model_cfg.spring_step    = cfg_data[11:0];
          REG_HEIGHT_FLOOR:   model_cfg.height_floor   = cfg_data[16:0];
          REG_HEIGHT_CEILING: model_cfg.height_ceiling = cfg_data[16:0];
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (expected_cmds.size() == 0) begin
          $error("result beat with nothing expected: col %0d row %0d height %0d status %0d",
                 out_col, out_row, target_height, clamp_status);
          mismatches++;
        end else begin
          want = expected_cmds.pop_front();
          if (out_col !== want.col) begin
            $error("out_col: expected %0d, got %0d", want.col, out_col);
            mismatches++;
          end
          if (out_row !== want.row) begin
            $error("out_row: expected %0d, got %0d", want.row, out_row);
            mismatches++;
          end
          if (target_height !== want.height) begin
            $error("target_height: expected %0d, got %0d", want.height, target_height);
            mismatches++;
          end
          if (clamp_status !== want.status) begin
            $error("clamp_status: expected %0d, got %0d", want.status, clamp_status);
            mismatches++;
          end
        end
      end
      if (in_valid && in_ready) begin
        next_beat = '{col: pin_col, row: pin_row, force_val: sensed_force,
                      meas: sensed_height, dt: step_time};
        expected_cmds.push_back(admit_pin(next_beat));
        beats_taken++;
      end
    end
  end

  // Input driver: works at the falling edge. A beat that has not been taken is held as is;
  // otherwise the driver either opens an idle burst, while idling is on, or presents the
  // next queued beat.
  always @(negedge clk) begin
    item_t b;
    if (rst) begin
      in_valid <= 1'b0;
      send_gap <= 0;
    end else if (in_valid && !in_took) begin
      // Beat still waiting for ready: keep valid and payload.
    end else if (send_gap > 0) begin
      in_valid <= 1'b0;
      send_gap <= send_gap - 1;
    end else if (idle_en && sensor_beats.size() != 0 && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      send_gap <= $urandom_range(0, 3);
    end else if (sensor_beats.size() != 0) begin
      b = sensor_beats.pop_front();
      in_valid      <= 1'b1;
      pin_col       <= b.col;
      pin_row       <= b.row;
      sensed_force  <= b.force_val;
      sensed_height <= b.meas;
      step_time     <= b.dt;
    end else begin
      in_valid <= 1'b0;
    end
  end

  // Result side back-pressure: random stalls while idling is on.
  always @(negedge clk) begin
    if (rst) begin
      out_ready <= 1'b1;
      recv_gap  <= 0;
    end else if (recv_gap > 0) begin
      out_ready <= 1'b0;
      recv_gap  <= recv_gap - 1;
    end else if (idle_en && $urandom_range(0, 4) == 0) begin
      out_ready <= 1'b0;
      recv_gap  <= $urandom_range(0, 3);
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Watchdog. The slowest legal run is far below this: the clearing pass, then for every
  // beat a pin repeat hazard, a full sender gap and a full receiver stall.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic queue_beat(input int c, input int r, input int f, input int h, input int dt);
    item_t b;
    b.col       = c[3:0];
    b.row       = r[3:0];
    b.force_val = f[11:0];
    b.meas      = h[16:0];
    b.dt        = dt[15:0];
    sensor_beats.push_back(b);
    beats_queued++;
  endtask

  // Holds the sender until every queued beat is taken and every result has come back.
  task automatic wait_drained();
    @(negedge clk);
    while (beats_taken != beats_queued || expected_cmds.size() != 0) @(negedge clk);
  endtask

  // One register write. Valid stays up between back-to-back writes; the caller lowers it.
  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [16:0] value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  // Mostly a sensible register value, sometimes raw 17-bit noise or an extreme.
  function automatic logic [16:0] reg_value(input int unsigned typical);
    case ($urandom_range(0, 5))
      0:       return 17'($urandom);
      1:       return ($urandom_range(0, 1) != 0) ? 17'h1FFFF : 17'h0;
      default: return 17'(typical);
    endcase
  endfunction

  // Stimulus. A short directed part covers the field extremes, the floor and ceiling
  // clamps, a floor placed above the ceiling, repeats of one pin while it is in flight,
  // writes to spare indexes and register data wider than the register. Random phases
  // follow, each starting from a drained block with fresh register values.
  initial begin
    int phase, n, c, r, f, h, sel, spring, jitter, band_lo, band_hi;
    int hot [4];

    repeat (11) @(negedge clk);
    rst <= 1'b0;

    // Reset settings. Measured 0 with the reset command lands under the floor; full scale
    // lands over the ceiling; measured 80000 with zero error lands exactly on the ceiling.
    queue_beat(0, 0, 0, 0, 0);
    queue_beat(15, 15, 4095, 131071, 65535);
    queue_beat(5, 3, 370, 80000, 0);
    queue_beat(5, 3, 4095, 40000, 65535);
    queue_beat(9, 12, 0, 40000, 65535);
    queue_beat(10, 7, 2048, 131071, 32768);
    queue_beat(0, 15, 4095, 100000, 65535);
    queue_beat(15, 0, 4095, 0, 65535);
    // One pin hammered back to back with alternating force.
    for (n = 0; n < 4; n++) queue_beat(2, 2, (n % 2) * 4095, 75000, 65535);
    wait_drained();

    // Largest gains and a spring that is full scale at column zero and zero elsewhere:
    // the velocity swings hard enough to drive the command below zero and far above
    // the top of the range.
    write_reg(REG_PROP_GAIN, 17'd65535);
    write_reg(REG_DERIV_GAIN, 17'd65535);
    write_reg(REG_SPRING_BASE, 17'd4095);
    write_reg(REG_SPRING_STEP, 17'd4095);
    write_reg(REG_HEIGHT_FLOOR, 17'd0);
    write_reg(REG_HEIGHT_CEILING, 17'd131071);
    @(negedge clk) cfg_valid <= 1'b0;
    queue_beat(1, 1, 4095, 0, 65535);
    queue_beat(0, 4, 0, 131071, 65535);
    queue_beat(1, 1, 0, 65000, 65535);
    queue_beat(14, 9, 2000, 50000, 0);
    wait_drained();

    // Floor above the ceiling, data wider than the registers, and spare indexes.
    write_reg(REG_HEIGHT_FLOOR, 17'd131071);
    write_reg(REG_HEIGHT_CEILING, 17'd0);
    write_reg(REG_PROP_GAIN, 17'h1FFFF);
    write_reg(REG_SPRING_BASE, 17'h1F123);
    write_reg(REG_SPARE_A, 17'h1FFFF);
    write_reg(REG_SPARE_B, 17'h0);
    @(negedge clk) cfg_valid <= 1'b0;
    queue_beat(3, 8, 1000, 90000, 40000);
    queue_beat(12, 13, 4095, 131071, 65535);
    queue_beat(7, 0, 0, 0, 0);

    for (phase = 0; phase < PHASES; phase++) begin
      // Every phase boundary is a full drain: the sender pauses until nothing is pending.
      wait_drained();
      idle_en = (phase % 3 != 2) && (phase != PHASES - 1);

      write_reg(REG_PROP_GAIN, reg_value($urandom_range(0, 2048)));
      write_reg(REG_DERIV_GAIN, reg_value($urandom_range(0, 1024)));
      write_reg(REG_SPRING_BASE, reg_value($urandom_range(0, 4095)));
      write_reg(REG_SPRING_STEP, reg_value($urandom_range(0, 300)));
      h = $urandom_range(0, 110000);
      write_reg(REG_HEIGHT_FLOOR, reg_value(h));
      write_reg(REG_HEIGHT_CEILING, reg_value(h + $urandom_range(0, 21071)));
      if ($urandom_range(0, 2) == 0)
        write_reg(($urandom_range(0, 1) != 0) ? REG_SPARE_A : REG_SPARE_B, 17'($urandom));
      @(negedge clk) cfg_valid <= 1'b0;

      // Measured heights mostly fall near the configured window so that all three
      // clamp outcomes keep turning up.
      band_lo = (model_cfg.height_floor < model_cfg.height_ceiling) ?
                int'(model_cfg.height_floor) : int'(model_cfg.height_ceiling);
      band_hi = (model_cfg.height_floor < model_cfg.height_ceiling) ?
                int'(model_cfg.height_ceiling) : int'(model_cfg.height_floor);
      band_lo = (band_lo > 4000) ? band_lo - 4000 : 0;
      band_hi = (band_hi < 127071) ? band_hi + 4000 : 131071;
      for (n = 0; n < 4; n++) hot[n] = $urandom_range(0, PIN_COUNT - 1);

      for (n = 0; n < PHASE_BEATS; n++) begin
        // A few hot pins build up velocity history and keep hitting the repeat hazard.
        if ($urandom_range(0, 9) < 6) begin
          sel = hot[$urandom_range(0, 3)];
          c = sel % GRID_COLS;
          r = sel / GRID_COLS;
        end else begin
          c = $urandom_range(0, GRID_COLS - 1);
          r = $urandom_range(0, GRID_ROWS - 1);
        end
        spring = int'(model_cfg.spring_base) - c * int'(model_cfg.spring_step);
        if (spring < 0) spring = 0;
        if ($urandom_range(0, 1) != 0) begin
          f = $urandom_range(0, 4095);
        end else begin
          jitter = $urandom_range(0, 600);
          f = spring + jitter - 300;
          if (f < 0) f = 0;
          if (f > 4095) f = 4095;
        end
        if ($urandom_range(0, 3) != 0) h = $urandom_range(band_lo, band_hi);
        else h = $urandom_range(0, 131071);
        queue_beat(c, r, f, h, $urandom_range(0, 65535));
      end
    end

    wait_drained();
    // Let the pipeline run empty; a stray result in this window is flagged by the monitor.
    repeat (12) @(negedge clk);
    if (mismatches == 0 && expected_cmds.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

// File: files.f
sv/pas_pkg.sv
sv/pas_ram.sv
sv/pas_cfg.sv
sv/pas_pipe.sv
sv/pin_array_spring_admittance.sv
verif/tb.sv
